// ===== hw/rtl/fdse_pkg.sv =====
// Shared types and constants for the frame delta skip encoder.
// Used by the channel interfaces, the result queue and the top level.
`default_nettype none

package fdse_pkg;

   // Width of a pixel word and of a code word.
   localparam int WORD_W = 16;
   // Width of the pixel position counter and of the skip counter.
   localparam int POS_W = 16;
   // Skip count above which a pending skip is split over two code words.
   localparam logic [WORD_W-1:0] SKIP_LIMIT = 16'h7fff;
   // Largest skip count that the counter holds.
   localparam logic [POS_W-1:0] SKIP_MAX = 16'hffff;
   // Default number of pixels in a frame.
   localparam int FRAME_PIXELS_DEFAULT = 49152;
   // Most results that one pixel can cause.
   localparam int MAX_RESULTS = 3;
   // Default depth of the result queue (a power of two).
   localparam int QUEUE_DEPTH_DEFAULT = 8;

   // One result item.
   typedef struct packed {
      logic [WORD_W-1:0] code_word;
      logic              is_skip;
      logic              last_of_run;
   } rsp_item_type;

   // Results that one pixel writes into the queue in one cycle.
   typedef struct packed {
      logic [1:0]                      num;
      rsp_item_type [MAX_RESULTS-1:0]  item;
   } push_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fdse_if.sv =====
// Valid/ready channel interfaces for pixel input and code word output.
// Depends on fdse_pkg for the word width.
`default_nettype none

interface fdse_req_if import fdse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] pixel_word;
   logic              is_reference;
   logic              frame_start;

   modport source (output valid, output pixel_word, output is_reference,
                   output frame_start, input ready);
   modport sink   (input valid, input pixel_word, input is_reference,
                   input frame_start, output ready);
endinterface

interface fdse_rsp_if import fdse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] code_word;
   logic              is_skip;
   logic              last_of_run;

   modport source (output valid, output code_word, output is_skip,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_word, input is_skip,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/frame_delta_skip_encoder_unit.sv =====
// Frame delta skip encoder, top level.
// Depends on fdse_pkg, fdse_if, fdse_ram and fdse_rsp_queue.
//
// Pixels arrive in raster order on the req_bus channel. A pixel flagged as
// reference is written into the reference memory at its position and gives
// no output. Any other pixel is compared with the stored one: a match adds
// to the skip count, a mismatch sends the pending skip count (split into
// 32767 and the remainder when larger) and then the pixel word itself on
// rsp_bus. The last code word caused by a pixel carries last_of_run. A
// frame_start pixel restarts the position and skip count; a skip run still
// pending at the end of a frame is dropped.
// One pixel is taken per cycle while the result queue has room. A code word
// reaches rsp_bus through the memory read and input registers, then the
// compare and the queue write. The result queue holds QUEUE_DEPTH words;
// input is held off once it would not fit the worst case of three words for
// the pixel in flight and three for the next one, so a stalled receiver
// stops the input after a few transfers with nothing lost.
// Reset clears the position, skip count and queue; the reference memory is
// not cleared and must be written by a reference frame before use.
`default_nettype none

module frame_delta_skip_encoder_unit import fdse_pkg::*; #(
   parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fdse_req_if.sink   req_bus,
   fdse_rsp_if.source rsp_bus
);

   localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

   // Position stage.
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  pos_cur;
   logic              in_frame;
   logic              accept;
   logic              space_ok;

   // Compare stage.
   logic              s1_valid_ff;
   logic [WORD_W-1:0] s1_pixel_ff;
   logic              s1_is_ref_ff;
   logic              s1_start_ff;
   logic              s1_in_frame_ff;
   logic [POS_W-1:0]  skip_ff, skip_in;
   logic [POS_W-1:0]  skip_cur;
   logic [POS_W-1:0]  skip_rem;
   logic [WORD_W-1:0] ram_rdata;
   logic              match;
   push_type          push;

   assign req_bus.ready = space_ok;
   assign accept        = req_bus.valid && req_bus.ready;

   // Position of the incoming pixel; it stops at the frame size.
   always_comb begin
      pos_cur  = req_bus.frame_start ? '0 : pos_ff;
      in_frame = (pos_cur < POS_W'(FRAME_PIXELS));
      pos_in   = pos_ff;
      if (accept) begin
         pos_in = in_frame ? pos_cur + POS_W'(1) : pos_cur;
      end
   end

   // Reference memory: reference pixels write, others read for the compare.
   fdse_ram #(
      .WIDTH (WORD_W),
      .DEPTH (FRAME_PIXELS)
   ) u_ref_ram (
      .clock (clock),
      .en    (accept && in_frame),
      .we    (req_bus.is_reference),
      .addr  (pos_cur[ADDR_W-1:0]),
      .wdata (req_bus.pixel_word),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         skip_ff     <= '0;
      end else begin
         pos_ff      <= pos_in;
         s1_valid_ff <= accept;
         skip_ff     <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= req_bus.pixel_word;
         s1_is_ref_ff   <= req_bus.is_reference;
         s1_start_ff    <= req_bus.frame_start;
         s1_in_frame_ff <= in_frame;
      end
   end

   // Compare with the stored pixel and build the code words for this pixel.
   always_comb begin
      skip_cur = s1_start_ff ? '0 : skip_ff;
      match    = s1_in_frame_ff && (ram_rdata == s1_pixel_ff);
      skip_rem = (skip_cur > POS_W'(SKIP_LIMIT)) ? skip_cur - POS_W'(SKIP_LIMIT) : skip_cur;
      skip_in  = skip_ff;
      push     = '0;
      if (s1_valid_ff) begin
         skip_in = skip_cur;
         if (!s1_is_ref_ff) begin
            if (match) begin
               skip_in = (skip_cur == SKIP_MAX) ? skip_cur : skip_cur + POS_W'(1);
            end else begin
               skip_in = '0;
               if (skip_cur > POS_W'(SKIP_LIMIT)) begin
                  push.num     = 2'd3;
                  push.item[0] = '{code_word: SKIP_LIMIT, is_skip: 1'b1, last_of_run: 1'b0};
                  push.item[1] = '{code_word: WORD_W'(skip_rem), is_skip: 1'b1,
                                   last_of_run: 1'b0};
                  push.item[2] = '{code_word: s1_pixel_ff, is_skip: 1'b0, last_of_run: 1'b1};
               end else if (skip_cur != '0) begin
                  push.num     = 2'd2;
                  push.item[0] = '{code_word: WORD_W'(skip_rem), is_skip: 1'b1,
                                   last_of_run: 1'b0};
                  push.item[1] = '{code_word: s1_pixel_ff, is_skip: 1'b0, last_of_run: 1'b1};
               end else begin
                  push.num     = 2'd1;
                  push.item[0] = '{code_word: s1_pixel_ff, is_skip: 1'b0, last_of_run: 1'b1};
               end
            end
         end
      end
   end

   // Result queue and output channel.
   fdse_rsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/fdse_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module fdse_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One access a cycle: either a write or a read.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fdse_rsp_queue.sv =====
// Result queue: takes up to three code words a cycle and drives the output channel.
// Depends on fdse_pkg and fdse_rsp_if.
`default_nettype none

module fdse_rsp_queue import fdse_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          space_ok,
   fdse_rsp_if.source    rsp_bus
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   // Room for the item in flight and one more newly accepted.
   localparam int FILL_LIMIT = DEPTH - 2 * MAX_RESULTS;

   rsp_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_idx [MAX_RESULTS];
   logic             pop;

   // Output side.
   assign rsp_bus.valid       = (count_ff != '0);
   assign rsp_bus.code_word   = entry_ff[rd_ptr_ff].code_word;
   assign rsp_bus.is_skip     = entry_ff[rd_ptr_ff].is_skip;
   assign rsp_bus.last_of_run = entry_ff[rd_ptr_ff].last_of_run;
   assign pop                 = rsp_bus.valid && rsp_bus.ready;
   assign space_ok            = (count_ff <= CNT_W'(FILL_LIMIT));

   // Pointer and fill count updates.
   always_comb begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         wr_idx[k] = wr_ptr_ff + PTR_W'(k);
      end
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.num);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; the slots written start at the write pointer.
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (2'(k) < push.num) begin
            entry_ff[wr_idx[k]] <= push.item[k];
         end
      end
   end

endmodule

`default_nettype wire
